// ===== sv/volume_gain_soft_clipper_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the volume / gain soft clipper
// Implication checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef VOLUME_GAIN_SOFT_CLIPPER_ASSERT_SVH
`define VOLUME_GAIN_SOFT_CLIPPER_ASSERT_SVH

// same-cycle implication
`define VGSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgsc assertion failed");

// implication across the full pipeline latency
`define VGSC_ASSERT_LAT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##PIPE_LAT (cons)) else $error("vgsc latency assertion failed");

`endif

// ===== sv/vgsc_pkg.sv =====
// ---------------------------------------------------------------------------
// vgsc_pkg
// Types and constants of the volume / gain soft clipper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgsc_pkg;

  localparam int PIPE_LAT = 13;   // request accept to out_valid
  localparam int NSTG     = 12;   // internal stages before the output register
  localparam int NHORNER  = 3;

  localparam logic [23:0] UNITY_Q16 = 24'd65536;
  localparam logic [16:0] KNEE_MAX  = 17'd65536;
  localparam logic signed [39:0] ONE_Q24 = 40'sd16777216;
  localparam logic signed [39:0] SAT_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] SAT_MIN = 40'sh8000000000;
  localparam logic [15:0] OMAG_FULL = 16'h8000;
  localparam logic [15:0] OUT_MAX   = 16'h7fff;

  // reset values of the registers
  localparam logic [23:0] RST_VOLUME = 24'd65536;
  localparam logic [23:0] RST_GAIN   = 24'd65536;
  localparam logic [16:0] RST_KLOW   = 17'd65536;
  localparam logic [23:0] RST_KHIGH  = 24'd65536;
  localparam logic signed [39:0] RST_CUBIC  = 40'sd0;
  localparam logic signed [39:0] RST_SQUARE = 40'sd0;
  localparam logic signed [39:0] RST_LINEAR = 40'sd16777216;
  localparam logic signed [39:0] RST_OFFSET = 40'sd0;

  typedef enum logic [2:0] {
    CFG_VOLUME      = 3'd0,
    CFG_GAIN        = 3'd1,
    CFG_KNEE_LOW    = 3'd2,
    CFG_KNEE_HIGH   = 3'd3,
    CFG_COEF_CUBIC  = 3'd4,
    CFG_COEF_SQUARE = 3'd5,
    CFG_COEF_LINEAR = 3'd6,
    CFG_COEF_OFFSET = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RGN_ID   = 2'd0,
    RGN_FULL = 2'd1,
    RGN_SPL  = 2'd2
  } region_t;

  // per-sample side data that rides along the pipeline
  typedef struct packed {
    logic [15:0] samp;
    logic        neg;
    region_t     region;
    logic [31:0] u;
    logic [15:0] id_mag;
  } ctl_t;

endpackage

// ===== sv/volume_gain_soft_clipper.sv =====
// ---------------------------------------------------------------------------
// volume_gain_soft_clipper
// Scales a PCM sample by volume and gain, then applies an odd-symmetric
// cubic-spline soft clipper and saturates back to 16 bits.
// ---------------------------------------------------------------------------
//  channel | ports                              | handshake
//  --------+------------------------------------+-------------------------------
//  input   | start, busy, in_sample_in          | request taken: start & !busy
//  result  | out_valid, out_sample_out          | one-cycle strobe, no backpressure
//  config  | cfg_we, cfg_addr, cfg_wdata        | write on cfg_we, no wait
//
//  One request per cycle, sustained. Accept to out_valid runs through the
//  chain of multiplies: mag*volume, the split *gain, and three Horner steps
//  (multiply, then add/saturate). Synchronous active-low reset clears the
//  valid bits and sets the config registers to their reset values; busy is
//  high only while rst_n is low. The receiver cannot stall, so the pipeline
//  simply advances every cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "volume_gain_soft_clipper_assert.svh"

module volume_gain_soft_clipper
  import vgsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  output logic signed [15:0] out_sample_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [39:0]        cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [23:0]        volume_r, gain_r, knee_high_r;
  logic [16:0]        knee_low_r;
  logic signed [39:0] coef_cubic_r, coef_square_r, coef_linear_r, coef_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r      <= RST_VOLUME;
      gain_r        <= RST_GAIN;
      knee_low_r    <= RST_KLOW;
      knee_high_r   <= RST_KHIGH;
      coef_cubic_r  <= RST_CUBIC;
      coef_square_r <= RST_SQUARE;
      coef_linear_r <= RST_LINEAR;
      coef_offset_r <= RST_OFFSET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_VOLUME:      volume_r      <= cfg_wdata[23:0];
        CFG_GAIN:        gain_r        <= cfg_wdata[23:0];
        CFG_KNEE_LOW:    knee_low_r    <= cfg_wdata[16:0];
        CFG_KNEE_HIGH:   knee_high_r   <= cfg_wdata[23:0];
        CFG_COEF_CUBIC:  coef_cubic_r  <= $signed(cfg_wdata);
        CFG_COEF_SQUARE: coef_square_r <= $signed(cfg_wdata);
        CFG_COEF_LINEAR: coef_linear_r <= $signed(cfg_wdata);
        CFG_COEF_OFFSET: coef_offset_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Effective knees: x1 capped at one, x2 raised to x1. Users must move config
  // only while the pipe is empty (unenforced); every stage reads these directly.
  logic [16:0] x1;
  logic [23:0] x2;
  logic        unity;

  always_comb begin
    x1    = (knee_low_r > KNEE_MAX) ? KNEE_MAX : knee_low_r;
    x2    = (knee_high_r < {7'd0, x1}) ? {7'd0, x1} : knee_high_r;
    unity = (volume_r == UNITY_Q16) && (gain_r == UNITY_Q16) && ({7'd0, x1} == x2);
  end

  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  // ---------------- pipeline registers ----------------
  logic [NSTG:1] vld_r;
  ctl_t          ctl_r   [1:NSTG];
  ctl_t          ctl_nxt [1:NSTG];

  logic [39:0] p1_r, p1_nxt;          // stage 2: |s| * volume
  logic [47:0] pl_r, pl_nxt;          // stage 3: low half * gain
  logic [39:0] ph_r, ph_nxt;          // stage 3: high half * gain
  logic [62:0] m_r, m_nxt;            // stage 4: |s| * volume * gain

  // Horner step k: multiply stage 6+2k, add/saturate stage 7+2k
  logic [47:0]        hp_r  [NHORNER], hp_nxt  [NHORNER];
  logic [31:0]        lp_r  [NHORNER], lp_nxt  [NHORNER];
  logic               hn_r  [NHORNER], hn_nxt  [NHORNER];
  logic signed [39:0] acc_r [NHORNER], acc_nxt [NHORNER];

  logic [15:0]        omag_r, omag_nxt;        // stage 12
  logic               out_valid_r;
  logic signed [15:0] out_sample_r, out_sample_nxt;

  logic [15:0] mag;
  logic [62:0] thr_lo, thr_hi;
  logic signed [39:0] acc_in [NHORNER];
  logic signed [39:0] coef_b [NHORNER];
  logic [31:0]        u_a    [NHORNER];
  logic [39:0]        amag   [NHORNER];
  logic [55:0]        lp_full[NHORNER];
  logic [48:0]        psum   [NHORNER];
  logic signed [50:0] bsum   [NHORNER];
  logic signed [39:0] lo_q24, clamp;

  always_comb begin
    // side data shifts along; individual stages fill in fields
    ctl_nxt[1]        = ctl_r[1];
    ctl_nxt[1].samp   = in_sample_in;
    for (int i = 2; i <= NSTG; i++) begin
      ctl_nxt[i] = ctl_r[i-1];
    end

    // stage 2: magnitude times volume
    mag            = ctl_r[1].samp[15] ? (~ctl_r[1].samp + 16'd1) : ctl_r[1].samp;
    ctl_nxt[2].neg = ctl_r[1].samp[15];
    p1_nxt         = 40'(mag) * 40'(volume_r);

    // stage 3: 40x24 product cut into two partial products
    pl_nxt = 48'(p1_r[23:0]) * 48'(gain_r);
    ph_nxt = 40'(p1_r[39:24]) * 40'(gain_r);

    // stage 4: recombine
    m_nxt = 63'({ph_r, 24'd0}) + 63'(pl_r);

    // stage 5: knee compare against x << 31
    thr_lo = {15'd0, x1, 31'd0};
    thr_hi = {8'd0, x2, 31'd0};
    if (m_r <= thr_lo) begin
      ctl_nxt[5].region = RGN_ID;
    end else if (m_r >= thr_hi) begin
      ctl_nxt[5].region = RGN_FULL;
    end else begin
      ctl_nxt[5].region = RGN_SPL;
    end
    ctl_nxt[5].u      = m_r[54:23];   // |y| in Q24, exact below the upper knee
    ctl_nxt[5].id_mag = m_r[47:32];   // exact below the lower knee

    // Horner steps
    coef_b[0] = coef_square_r;
    coef_b[1] = coef_linear_r;
    coef_b[2] = coef_offset_r;
    acc_in[0] = coef_cubic_r;
    acc_in[1] = acc_r[0];
    acc_in[2] = acc_r[1];
    for (int k = 0; k < NHORNER; k++) begin
      u_a[k]     = ctl_r[5 + 2*k].u;
      amag[k]    = acc_in[k][39] ? 40'(-acc_in[k]) : 40'(acc_in[k]);
      hp_nxt[k]  = 48'(amag[k][39:24]) * 48'(u_a[k]);
      lp_full[k] = 56'(amag[k][23:0]) * 56'(u_a[k]);
      lp_nxt[k]  = lp_full[k][55:24];
      hn_nxt[k]  = acc_in[k][39];

      psum[k] = 49'(hp_r[k]) + 49'(lp_r[k]);
      bsum[k] = hn_r[k] ? (51'(coef_b[k]) - $signed({2'b00, psum[k]}))
                        : (51'(coef_b[k]) + $signed({2'b00, psum[k]}));
      if (bsum[k][50:39] == {12{bsum[k][39]}}) begin
        acc_nxt[k] = bsum[k][39:0];
      end else begin
        acc_nxt[k] = bsum[k][50] ? SAT_MIN : SAT_MAX;
      end
    end

    // stage 12: region select, spline result bounded to [x1, 1]
    lo_q24 = $signed({15'd0, x1, 8'd0});
    clamp  = (acc_r[2] <= lo_q24) ? lo_q24 : acc_r[2];
    clamp  = (clamp >= ONE_Q24) ? ONE_Q24 : clamp;
    case (ctl_r[11].region)
      RGN_ID:   omag_nxt = ctl_r[11].id_mag;
      RGN_FULL: omag_nxt = OMAG_FULL;
      RGN_SPL:  omag_nxt = clamp[24:9];
      default:  omag_nxt = OMAG_FULL;
    endcase

    // stage 13: unity passes the sample through; else sign back on, saturate the positive side
    if (unity) begin
      out_sample_nxt = ctl_r[12].samp;
    end else if (ctl_r[12].neg) begin
      out_sample_nxt = $signed(~omag_r + 16'd1);
    end else begin
      out_sample_nxt = $signed((omag_r > OUT_MAX) ? OUT_MAX : omag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[NSTG-1:1], accept};
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= NSTG; i++) begin
      ctl_r[i] <= ctl_nxt[i];
    end
    p1_r <= p1_nxt;
    pl_r <= pl_nxt;
    ph_r <= ph_nxt;
    m_r  <= m_nxt;
    for (int k = 0; k < NHORNER; k++) begin
      hp_r[k]  <= hp_nxt[k];
      lp_r[k]  <= lp_nxt[k];
      hn_r[k]  <= hn_nxt[k];
      acc_r[k] <= acc_nxt[k];
    end
    omag_r       <= omag_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // ---------------- assertions ----------------
  // every result traces back to a request accepted one full pipeline latency earlier
  `VGSC_ASSERT_IMP(a_no_phantom, out_valid, $past(accept, PIPE_LAT))
  // every request yields a result after the pipeline latency
  `VGSC_ASSERT_LAT(a_result_arrives, accept, out_valid)
  // silence stays silent whatever the settings
  `VGSC_ASSERT_LAT(a_zero_passes, accept && (in_sample_in == 16'sd0), out_sample_out == 16'sd0)
  // a nonzero result keeps the sign of its sample
  `VGSC_ASSERT_IMP(a_sign_kept, out_valid && (out_sample_out != 16'sd0),
                   out_sample_out[15] == $past(in_sample_in[15], PIPE_LAT))

endmodule
